>>> rtl/scd_pkg.sv
// Shared types, widths and constants of the scan context descriptor builder.
package scd_pkg;

  localparam int MAX_RINGS   = 32;
  localparam int MAX_SECTORS = 64;
  localparam int COORD_W     = 20;

  localparam int RING_W   = 5;
  localparam int SECT_W   = 6;
  localparam int ADDR_W   = RING_W + SECT_W;
  localparam int HGT_W    = 21;
  localparam int SUM_W    = 27;
  localparam int MAG_W    = COORD_W;
  localparam int R2_W     = 2 * MAG_W;
  localparam int MR2_W    = 38;
  localparam int TGT_W    = 50;
  localparam int MUL_W    = 25;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ANG_W    = 25;
  localparam int ANGA_W   = 26;
  localparam int CV_W     = 33;
  localparam int STEP_W   = 5;
  localparam int STGT_W   = 32;
  localparam int ACC_W    = 33;
  localparam int CNT_W    = 7;
  localparam int REM_W    = 7;

  localparam int CORDIC_STEPS = 20;
  localparam int DIV_STEPS    = SUM_W;

  localparam logic [ANG_W-1:0] QUARTER_TURN = ANG_W'(90 * 65536);
  localparam logic [ANG_W-1:0] HALF_TURN    = ANG_W'(180 * 65536);
  localparam logic [ANG_W-1:0] FULL_TURN    = ANG_W'(360 * 65536);
  localparam int               HEIGHT_OFFSET = 512;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 19;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_DEG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_CNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECT_CNT   = 2'd3;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SQX, S_SQY, S_MR2, S_NR2, S_TLO, S_THI, S_CHK,
    S_RING, S_CORD, S_CWAIT, S_SMUL, S_SMUL2, S_SECT, S_HRD, S_HUPD,
    S_RRD, S_RDIV, S_RFIX
  } scd_state_e;

  // atan(2^-i) in 1/65536 degree, rounded to nearest.
  function automatic logic [21:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/scd_if.sv
// Handshake channel interfaces of the scan context descriptor builder.
interface scd_in_if;
  import scd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic                      first;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic [RING_W-1:0]         read_ring;
  logic [SECT_W-1:0]         read_sector;
  modport source (output valid, kind, first, point_x, point_y, point_z, read_ring,
                  read_sector, input ready);
  modport sink (input valid, kind, first, point_x, point_y, point_z, read_ring,
                read_sector, output ready);
endinterface

interface scd_out_if;
  import scd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [HGT_W-1:0] bin_height;
  logic signed [HGT_W-1:0] row_key;
  logic                    occupied;
  modport source (output valid, bin_height, row_key, occupied, input ready);
  modport sink (input valid, bin_height, row_key, occupied, output ready);
endinterface

interface scd_cfg_if;
  import scd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/scd_cordic.sv
// Iterative vectoring CORDIC giving the first-quadrant angle of a vector.
module scd_cordic (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [scd_pkg::MAG_W-1:0]   ax_i,
  input  logic [scd_pkg::MAG_W-1:0]   ay_i,
  output logic                        done_o,
  output logic [scd_pkg::ANG_W-1:0]   angle_o
);
  import scd_pkg::*;

  logic signed [CV_W-1:0]   x_q, y_q, dx, dy;
  logic signed [ANGA_W-1:0] ang_q, atan_s;
  logic [STEP_W-1:0]        step_q;
  logic                     busy_q, done_q;

  assign dx     = y_q >>> step_q;
  assign dy     = x_q >>> step_q;
  assign atan_s = $signed({4'b0, atan_entry(step_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= $signed({3'b0, ax_i, 10'b0});
      y_q   <= $signed({3'b0, ay_i, 10'b0});
      ang_q <= '0;
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q   <= x_q + dx;
        y_q   <= y_q - dy;
        ang_q <= ang_q + atan_s;
      end else begin
        x_q   <= x_q - dx;
        y_q   <= y_q + dy;
        ang_q <= ang_q - atan_s;
      end
    end
  end

  // The accumulated angle may overshoot slightly; clamp to the quadrant.
  always_comb begin
    if (ang_q < 0) begin
      angle_o = '0;
    end else if (ang_q > $signed({1'b0, QUARTER_TURN})) begin
      angle_o = QUARTER_TURN;
    end else begin
      angle_o = ang_q[ANG_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

>>> rtl/scan_context_descriptor_build.sv
// Top level of the scan context descriptor builder: sequencer, grid store and ring sums.
//
// The block keeps a 32 x 64 polar height grid. A point word (kind 0) is binned by
// its exact squared radius and by a 20-step CORDIC bearing into a ring and a
// sector; each bin keeps its greatest z + 2 m, and each ring keeps a running sum
// of its bin heights. A read word (kind 1) returns one bin's height and occupancy
// and the ring key, the floor of the ring sum over the configured sector count.
// Items are handled one at a time, and the input is not ready while one is in
// work. A kept point uses one shared 25 x 25 multiplier stepped by the sequencer,
// a linear ring search and sector search of one compare per cycle, and the
// CORDIC at one rotation per cycle; a point on an axis skips the CORDIC, and a
// dropped point ends after the radius check. A read runs a one-bit-per-cycle
// divider. The grid lives in one memory with a write port and a read port, and
// after reset and on every point with the first flag set a clearing sweep over
// every grid address runs before work goes on. Configuration writes are taken
// at any time, and must come while idle.
module scan_context_descriptor_build (
  input  logic clk_i,
  input  logic rst_ni,
  scd_cfg_if.sink   cfg_i,
  scd_in_if.sink    in_i,
  scd_out_if.source out_o
);
  import scd_pkg::*;

  // Configuration registers.
  logic [18:0] roi_radius_q;
  logic [8:0]  span_deg_q;
  logic [5:0]  ring_cnt_q;
  logic [6:0]  sect_cnt_q;

  // Effective counts: zero acts as one, oversized values clamp to the store.
  logic [5:0] nr_eff;
  logic [6:0] ns_eff;
  logic [8:0] span_eff;

  scd_state_e state_q, state_d;

  // Latched item.
  logic signed [COORD_W-1:0] x_q, y_q, z_q;
  logic [RING_W-1:0]         rd_ring_q;
  logic [SECT_W-1:0]         rd_sec_q;
  logic                      pend_q;

  logic [MAG_W-1:0] ax, ay;

  // Shared multiplier.
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_q;

  // Arithmetic working registers.
  logic [R2_W-1:0]   r2_q;
  logic [MR2_W-1:0]  mr2_q;
  logic [10:0]       nr2_q;
  logic [TGT_W-1:0]  tgt_q, sq_q, inc_q;
  logic [CNT_W-1:0]  k_q;
  logic [RING_W-1:0] ring_q;
  logic [SECT_W-1:0] sector_q;
  logic [ANG_W-1:0]  tq_q, tq_quad;
  logic [STGT_W-1:0] stgt_q;
  logic [ACC_W-1:0]  acc_q, span_step;
  logic              ring_go, sect_go;

  // Clear sweep.
  logic [ADDR_W-1:0] clr_cnt_q;

  // Grid memory: bit 21 is the occupied flag, bits 20:0 the height.
  logic [HGT_W:0]    grid_mem [MAX_RINGS * MAX_SECTORS];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [HGT_W:0]    mem_wdata, mem_rdata_q;

  // Ring sums, one register per ring, selected through a single read index.
  logic signed [SUM_W-1:0] ring_sum_q [MAX_RINGS];
  logic [RING_W-1:0]       rs_idx;
  logic signed [SUM_W-1:0] rs_val;

  // Height update.
  logic signed [HGT_W-1:0] h_new, h_old;
  logic                    upd;
  logic signed [SUM_W-1:0] delta;

  // Divider for the ring key.
  logic [SUM_W-1:0]  quo_q, quo_n, kmag;
  logic [REM_W-1:0]  rem_q, rem_n;
  logic [REM_W:0]    rem_sh;
  logic              rem_ge, neg_q;
  logic [STEP_W-1:0] div_cnt_q;
  logic [SUM_W-1:0]  key_full;

  // CORDIC.
  logic             cor_start, cor_done;
  logic [ANG_W-1:0] cor_angle;

  // Output register.
  logic                    out_valid_q;
  logic signed [HGT_W-1:0] out_h_q, out_key_q;
  logic                    out_occ_q;
  logic                    out_free;

  // ---------------------------------------------------------------------------
  // Configuration port.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_radius_q <= 19'd20480;
      span_deg_q   <= 9'd360;
      ring_cnt_q   <= 6'd20;
      sect_cnt_q   <= 7'd60;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ROI_RADIUS: roi_radius_q <= cfg_i.data;
        CFG_SPAN_DEG:   span_deg_q   <= cfg_i.data[8:0];
        CFG_RING_CNT:   ring_cnt_q   <= cfg_i.data[5:0];
        CFG_SECT_CNT:   sect_cnt_q   <= cfg_i.data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ring_cnt_q == '0) begin
      nr_eff = 6'd1;
    end else if (ring_cnt_q > 6'(MAX_RINGS)) begin
      nr_eff = 6'(MAX_RINGS);
    end else begin
      nr_eff = ring_cnt_q;
    end
    if (sect_cnt_q == '0) begin
      ns_eff = 7'd1;
    end else if (sect_cnt_q > 7'(MAX_SECTORS)) begin
      ns_eff = 7'(MAX_SECTORS);
    end else begin
      ns_eff = sect_cnt_q;
    end
    span_eff = (span_deg_q == '0) ? 9'd1 : span_deg_q;
  end

  // ---------------------------------------------------------------------------
  // Derived values.
  assign ax = x_q[COORD_W-1] ? MAG_W'(-x_q) : MAG_W'(x_q);
  assign ay = y_q[COORD_W-1] ? MAG_W'(-y_q) : MAG_W'(y_q);

  // Ring k is reached while (k * radius limit)^2 <= ring count^2 * r^2.
  assign ring_go = (k_q < CNT_W'(nr_eff)) && (sq_q <= tgt_q);
  // Sector k is reached while k * span * 65536 <= sector count * bearing.
  assign sect_go = (k_q < ns_eff) && (acc_q <= ACC_W'(stgt_q));
  assign span_step = ACC_W'({span_eff, 16'b0});

  // Quadrant of the CORDIC angle; only 360 - 0 needs the wrap.
  always_comb begin
    if (!x_q[COORD_W-1] && !y_q[COORD_W-1]) begin
      tq_quad = cor_angle;
    end else if (x_q[COORD_W-1] && !y_q[COORD_W-1]) begin
      tq_quad = HALF_TURN - cor_angle;
    end else if (x_q[COORD_W-1]) begin
      tq_quad = HALF_TURN + cor_angle;
    end else if (cor_angle == '0) begin
      tq_quad = '0;
    end else begin
      tq_quad = FULL_TURN - cor_angle;
    end
  end

  // A 20-bit z plus the offset always fits the 21-bit height range.
  assign h_new  = $signed({z_q[COORD_W-1], z_q}) + HGT_W'(HEIGHT_OFFSET);
  assign h_old  = mem_rdata_q[HGT_W] ? $signed(mem_rdata_q[HGT_W-1:0]) : '0;
  assign upd    = !mem_rdata_q[HGT_W] || (h_new > h_old);
  assign delta  = SUM_W'(h_new) - SUM_W'(h_old);

  assign rs_idx = (state_q == S_RRD) ? rd_ring_q : ring_q;
  assign rs_val = ring_sum_q[rs_idx];

  // One restoring division step on the magnitude of the ring sum.
  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, ns_eff};
  assign rem_n  = rem_ge ? REM_W'(rem_sh - {1'b0, ns_eff}) : rem_sh[REM_W-1:0];
  assign quo_n  = {quo_q[SUM_W-2:0], rem_ge};
  // Floor division: a negative sum with a remainder rounds one further down.
  assign kmag     = quo_q + SUM_W'(rem_q != '0);
  assign key_full = neg_q ? -kmag : quo_q;

  assign out_free = !out_valid_q || out_o.ready;

  // ---------------------------------------------------------------------------
  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = {ring_q, sector_q};
    cor_start = 1'b0;
    in_i.ready = 1'b0;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt_q == '1) begin
          state_d = pend_q ? S_SQX : S_IDLE;
        end
      end
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.kind) begin
            state_d = S_RRD;
          end else if (in_i.first) begin
            state_d = S_CLEAR;
          end else begin
            state_d = S_SQX;
          end
        end
      end
      S_SQX: begin
        mul_a   = MUL_W'(ax);
        mul_b   = MUL_W'(ax);
        state_d = S_SQY;
      end
      S_SQY: begin
        mul_a   = MUL_W'(ay);
        mul_b   = MUL_W'(ay);
        state_d = S_MR2;
      end
      S_MR2: begin
        mul_a   = MUL_W'(roi_radius_q);
        mul_b   = MUL_W'(roi_radius_q);
        state_d = S_NR2;
      end
      S_NR2: begin
        mul_a   = MUL_W'(nr_eff);
        mul_b   = MUL_W'(nr_eff);
        state_d = S_TLO;
      end
      S_TLO: begin
        mul_a   = MUL_W'(r2_q[MAG_W-1:0]);
        mul_b   = MUL_W'(prod_q[10:0]);
        state_d = S_THI;
      end
      S_THI: begin
        mul_a   = MUL_W'(r2_q[R2_W-1:MAG_W]);
        mul_b   = MUL_W'(nr2_q);
        state_d = S_CHK;
      end
      S_CHK: begin
        state_d = (MR2_W'(r2_q) > mr2_q || r2_q[R2_W-1:MR2_W] != '0) ? S_IDLE : S_RING;
      end
      S_RING: begin
        if (!ring_go) begin
          state_d = S_CORD;
        end
      end
      S_CORD: begin
        if (x_q == '0 || y_q == '0) begin
          state_d = S_SMUL;
        end else begin
          cor_start = 1'b1;
          state_d   = S_CWAIT;
        end
      end
      S_CWAIT: begin
        if (cor_done) begin
          state_d = S_SMUL;
        end
      end
      S_SMUL: begin
        mul_a   = tq_q;
        mul_b   = MUL_W'(ns_eff);
        state_d = S_SMUL2;
      end
      S_SMUL2: begin
        state_d = S_SECT;
      end
      S_SECT: begin
        if (!sect_go) begin
          state_d = S_HRD;
        end
      end
      S_HRD: begin
        mem_re  = 1'b1;
        state_d = S_HUPD;
      end
      S_HUPD: begin
        mem_we    = upd;
        mem_waddr = {ring_q, sector_q};
        mem_wdata = {1'b1, h_new};
        state_d   = S_IDLE;
      end
      S_RRD: begin
        mem_re    = 1'b1;
        mem_raddr = {rd_ring_q, rd_sec_q};
        state_d   = S_RDIV;
      end
      S_RDIV: begin
        if (div_cnt_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = S_RFIX;
        end
      end
      S_RFIX: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_RINGS; i++) begin
        ring_sum_q[i] <= '0;
      end
    end else begin
      // A finished read loads the output register; otherwise a taken word empties it.
      if (state_q == S_RFIX && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
        end
        S_IDLE: begin
          if (in_i.valid && !in_i.kind && in_i.first) begin
            pend_q    <= 1'b1;
            clr_cnt_q <= '0;
            for (int i = 0; i < MAX_RINGS; i++) begin
              ring_sum_q[i] <= '0;
            end
          end
        end
        S_HUPD: begin
          if (upd) begin
            ring_sum_q[ring_q] <= rs_val + delta;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers. The product of a multiply state is seen in the state after it.
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a * mul_b);
    case (state_q)
      S_IDLE: begin
        x_q       <= in_i.point_x;
        y_q       <= in_i.point_y;
        z_q       <= in_i.point_z;
        rd_ring_q <= in_i.read_ring;
        rd_sec_q  <= in_i.read_sector;
      end
      S_SQY: r2_q <= R2_W'(prod_q);
      S_MR2: r2_q <= r2_q + R2_W'(prod_q);
      S_NR2: mr2_q <= MR2_W'(prod_q);
      S_TLO: nr2_q <= prod_q[10:0];
      S_THI: tgt_q <= TGT_W'(prod_q);
      S_CHK: begin
        tgt_q  <= tgt_q + (TGT_W'(prod_q) << MAG_W);
        k_q    <= CNT_W'(1);
        ring_q <= '0;
        sq_q   <= TGT_W'(mr2_q);
        inc_q  <= TGT_W'(mr2_q) + (TGT_W'(mr2_q) << 1);
      end
      S_RING: begin
        if (ring_go) begin
          ring_q <= k_q[RING_W-1:0];
          k_q    <= k_q + 1'b1;
          sq_q   <= sq_q + inc_q;
          inc_q  <= inc_q + (TGT_W'(mr2_q) << 1);
        end
      end
      S_CORD: begin
        if (y_q == '0) begin
          tq_q <= x_q[COORD_W-1] ? HALF_TURN : '0;
        end else if (x_q == '0) begin
          tq_q <= y_q[COORD_W-1] ? (HALF_TURN + QUARTER_TURN) : QUARTER_TURN;
        end
      end
      S_CWAIT: begin
        if (cor_done) begin
          tq_q <= tq_quad;
        end
      end
      S_SMUL2: begin
        stgt_q   <= prod_q[STGT_W-1:0];
        k_q      <= CNT_W'(1);
        sector_q <= '0;
        acc_q    <= span_step;
      end
      S_SECT: begin
        if (sect_go) begin
          sector_q <= k_q[SECT_W-1:0];
          k_q      <= k_q + 1'b1;
          acc_q    <= acc_q + span_step;
        end
      end
      S_RRD: begin
        neg_q     <= rs_val[SUM_W-1];
        quo_q     <= rs_val[SUM_W-1] ? SUM_W'(-rs_val) : SUM_W'(rs_val);
        rem_q     <= '0;
        div_cnt_q <= '0;
      end
      S_RDIV: begin
        quo_q     <= quo_n;
        rem_q     <= rem_n;
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      S_RFIX: begin
        if (out_free) begin
          out_occ_q <= mem_rdata_q[HGT_W];
          out_h_q   <= h_old;
          out_key_q <= key_full[HGT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Grid memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= grid_mem[mem_raddr];
    end
  end

  scd_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .ax_i    (ax),
    .ay_i    (ay),
    .done_o  (cor_done),
    .angle_o (cor_angle)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.bin_height = out_h_q;
  assign out_o.row_key    = out_key_q;
  assign out_o.occupied   = out_occ_q;

  // ---------------------------------------------------------------------------
  // Assertions.

  // The ring search never runs past the last configured ring.
  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SECT) |-> ({1'b0, ring_q} < nr_eff))
    else $error("ring index beyond configured ring count");

  // The sector search never runs past the last configured sector.
  a_sect_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HRD) |-> ({1'b0, sector_q} < ns_eff))
    else $error("sector index beyond configured sector count");

  // The CORDIC only finishes while the sequencer waits for it.
  a_cordic_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> (state_q == S_CWAIT))
    else $error("CORDIC finished outside its wait state");

  // A finished read always presents its result in the output register.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RFIX && state_d == S_IDLE) |=> out_valid_q)
    else $error("read result not presented");

endmodule

>>> tb/sv/scan_context_descriptor_build_tb.sv
// Self-checking testbench of the scan context descriptor builder.
`timescale 1ns / 100ps

module scan_context_descriptor_build_tb;
  import scd_pkg::*;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_READ  = 1'b1;
  // Longest quiet stretch that a point word can still need: a clearing sweep
  // plus the slowest binning at the largest grid, with margin.
  localparam int SETTLE_CYCLES = 2600;
  localparam int CYCLE_LIMIT   = 10000000;
  localparam int RANDOM_WORDS  = 220;

  typedef struct {
    logic                      kind;
    logic                      first;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [RING_W-1:0]         ring;
    logic [SECT_W-1:0]         sector;
  } grid_word_t;

  typedef struct {
    logic signed [HGT_W-1:0] height;
    logic signed [HGT_W-1:0] key;
    logic                    occupied;
  } bin_read_t;

  // Grid predictor plus the queue of bin reads still to come back.
  class grid_scoreboard;
    longint    roi_radius, span_deg, ring_cnt, sect_cnt;
    longint    heights[MAX_RINGS*MAX_SECTORS];
    bit        occ[MAX_RINGS*MAX_SECTORS];
    longint    sums[MAX_RINGS];
    bin_read_t reads_due[$];
    int        errors;
    longint    atan_deg[CORDIC_STEPS] = '{2949120, 1740967, 919879, 466945, 234379,
      117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

    function new();
      roi_radius = 20480;
      span_deg = 360;
      ring_cnt = 20;
      sect_cnt = 60;
      errors = 0;
      clear_grid();
    endfunction

    function void clear_grid();
      foreach (heights[i]) begin
        heights[i] = 0;
        occ[i] = 0;
      end
      foreach (sums[i]) sums[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        CFG_ROI_RADIUS: roi_radius = val;
        CFG_SPAN_DEG:   span_deg = val[8:0];
        CFG_RING_CNT:   ring_cnt = val[5:0];
        CFG_SECT_CNT:   sect_cnt = val[6:0];
        default: ;
      endcase
    endfunction

    function longint rings_used();
      if (ring_cnt == 0) return 1;
      return (ring_cnt > MAX_RINGS) ? MAX_RINGS : ring_cnt;
    endfunction

    function longint sectors_used();
      if (sect_cnt == 0) return 1;
      return (sect_cnt > MAX_SECTORS) ? MAX_SECTORS : sect_cnt;
    endfunction

    // Bearing in 1/65536 degree; axis points are exact, others use CORDIC.
    function longint bearing_of(longint x, longint y);
      longint cx, cy, ang, dx, dy, t;
      if (y == 0) return (x >= 0) ? 0 : 180 * 65536;
      if (x == 0) return (y > 0) ? 90 * 65536 : 270 * 65536;
      cx = ((x < 0) ? -x : x) * 1024;
      cy = ((y < 0) ? -y : y) * 1024;
      ang = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy > 0) begin
          cx += dx; cy -= dy; ang += atan_deg[i];
        end else begin
          cx -= dx; cy += dy; ang -= atan_deg[i];
        end
      end
      if (ang < 0) ang = 0;
      if (ang > 90 * 65536) ang = 90 * 65536;
      if (x > 0 && y > 0) t = ang;
      else if (x < 0 && y > 0) t = 180 * 65536 - ang;
      else if (x < 0) t = 180 * 65536 + ang;
      else t = 360 * 65536 - ang;
      if (t >= 360 * 65536) t -= 360 * 65536;
      return t;
    endfunction

    function void add_point(longint x, longint y, longint z);
      longint nr, ns, span, r2, ring, sector, t, h, old;
      int idx;
      nr = rings_used();
      ns = sectors_used();
      span = (span_deg == 0) ? 1 : span_deg;
      r2 = x * x + y * y;
      if (r2 > roi_radius * roi_radius) return;
      ring = 0;
      for (longint k = 1; k < nr; k++) begin
        if ((k * roi_radius) * (k * roi_radius) <= nr * nr * r2) ring = k;
        else break;
      end
      t = bearing_of(x, y);
      sector = 0;
      for (longint k = 1; k < ns; k++) begin
        if (k * span * 65536 <= ns * t) sector = k;
        else break;
      end
      h = z + HEIGHT_OFFSET;
      if (h > 1048575) h = 1048575;
      if (h < -1048576) h = -1048576;
      idx = int'(ring * MAX_SECTORS + sector);
      old = occ[idx] ? heights[idx] : 0;
      if (!occ[idx] || h > old) begin
        sums[ring] += h - old;
        heights[idx] = h;
        occ[idx] = 1;
      end
    endfunction

    function void note_word(grid_word_t w);
      bin_read_t r;
      longint s, d, q;
      int idx;
      if (w.kind == KIND_POINT) begin
        if (w.first) clear_grid();
        add_point(w.x, w.y, w.z);
      end else begin
        idx = w.ring * MAX_SECTORS + w.sector;
        r.occupied = occ[idx];
        r.height = occ[idx] ? HGT_W'(heights[idx]) : '0;
        s = sums[w.ring];
        d = sectors_used();
        q = s / d;
        if ((s % d) != 0 && s < 0) q--;
        r.key = HGT_W'(q);
        reads_due.insert(reads_due.size(), r);
      end
    endfunction

    function void check_result(bin_read_t got);
      bin_read_t want;
      if (reads_due.size() == 0) begin
        $error("bin read result arrived with none pending");
        errors++;
        return;
      end
      want = reads_due.pop_front();
      if (got.height !== want.height) begin
        $error("bin_height expected %0d got %0d", want.height, got.height);
        errors++;
      end
      if (got.key !== want.key) begin
        $error("row_key expected %0d got %0d", want.key, got.key);
        errors++;
      end
      if (got.occupied !== want.occupied) begin
        $error("occupied expected %0d got %0d", want.occupied, got.occupied);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  scd_cfg_if cfg_ch ();
  scd_in_if  word_ch ();
  scd_out_if read_ch ();

  scan_context_descriptor_build dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch.sink),
    .in_i   (word_ch.sink),
    .out_o  (read_ch.source)
  );

  grid_scoreboard sb = new();

  // Idling is on for most of the run; the closing phase runs at full rate.
  bit idle_on = 1'b1;
  // Set once by the stimulus to make the result side hold off for a long time.
  bit hold_request = 1'b0;
  // Current ROI radius and grid counts, used to aim the random points.
  longint aim_radius = 20480;
  int     aim_rings = 20;
  int     aim_sectors = 60;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit: a hung handshake ends the run as a failure.
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side: check every accepted read, then decide next cycle's ready.
  // Random short stalls, and one long hold-off when asked, so the block fills.
  initial begin
    int stall_left;
    bin_read_t got;
    stall_left = 0;
    read_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (read_ch.valid && read_ch.ready) begin
        got.height = read_ch.bin_height;
        got.key = read_ch.row_key;
        got.occupied = read_ch.occupied;
        sb.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = 600;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        read_ch.ready <= 1'b0;
      end else begin
        read_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one word, after a random gap when idling is on, and waits for it
  // to be taken. Valid stays high across back-to-back words.
  task automatic send_word(grid_word_t w);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      word_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    word_ch.valid <= 1'b1;
    word_ch.kind <= w.kind;
    word_ch.first <= w.first;
    word_ch.point_x <= w.x;
    word_ch.point_y <= w.y;
    word_ch.point_z <= w.z;
    word_ch.read_ring <= w.ring;
    word_ch.read_sector <= w.sector;
    do @(posedge clk_i); while (!word_ch.ready);
    sb.note_word(w);
  endtask

  // Offers one register write; valid stays high across back-to-back writes.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
  endtask

  // Waits until every read is back and the block has had time to finish a
  // point, which produces no result of its own.
  task automatic wait_quiet();
    word_ch.valid <= 1'b0;
    while (sb.reads_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned radius, int unsigned theta, int unsigned rings,
                           int unsigned sectors);
    wait_quiet();
    write_reg(CFG_ROI_RADIUS, CFG_DAT_W'(radius));
    write_reg(CFG_SPAN_DEG, CFG_DAT_W'(theta));
    write_reg(CFG_RING_CNT, CFG_DAT_W'(rings));
    write_reg(CFG_SECT_CNT, CFG_DAT_W'(sectors));
    cfg_ch.valid <= 1'b0;
    aim_radius = radius;
    aim_rings = (rings == 0) ? 1 : ((rings > MAX_RINGS) ? MAX_RINGS : rings);
    aim_sectors = (sectors == 0) ? 1 : ((sectors > MAX_SECTORS) ? MAX_SECTORS : sectors);
  endtask

  function automatic grid_word_t point_word(longint x, longint y, longint z, bit first);
    grid_word_t w;
    w.kind = KIND_POINT;
    w.first = first;
    w.x = COORD_W'(x);
    w.y = COORD_W'(y);
    w.z = COORD_W'(z);
    w.ring = RING_W'($urandom);
    w.sector = SECT_W'($urandom);
    return w;
  endfunction

  function automatic grid_word_t read_word(int ring, int sector);
    grid_word_t w;
    w.kind = KIND_READ;
    w.first = 1'($urandom);
    w.x = COORD_W'($urandom);
    w.y = COORD_W'($urandom);
    w.z = COORD_W'($urandom);
    w.ring = RING_W'(ring);
    w.sector = SECT_W'(sector);
    return w;
  endfunction

  // A coordinate: mostly inside the ROI, some of a random bit width, a few
  // from the whole field.
  function automatic longint pick_coord();
    int sel, w;
    longint v, lim;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      lim = (aim_radius * 7) / 10;
      v = $urandom_range(0, int'(lim));
    end else if (sel < 9) begin
      w = $urandom_range(1, 19);
      v = $urandom_range(0, (1 << w) - 1);
    end else begin
      return longint'($signed(COORD_W'($urandom)));
    end
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic grid_word_t random_word();
    longint z;
    if ($urandom_range(0, 9) < 6) begin
      z = $urandom_range(0, 3) == 0 ? longint'($signed(COORD_W'($urandom)))
                                    : longint'($urandom_range(0, 2000)) - 1000;
      return point_word(pick_coord(), pick_coord(), z, $urandom_range(0, 59) == 0);
    end
    if ($urandom_range(0, 9) < 8)
      return read_word($urandom_range(0, aim_rings - 1), $urandom_range(0, aim_sectors - 1));
    return read_word($urandom_range(0, MAX_RINGS - 1), $urandom_range(0, MAX_SECTORS - 1));
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_word(random_word());
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    word_ch.valid = 1'b0;
    word_ch.kind = KIND_POINT;
    word_ch.first = 1'b0;
    word_ch.point_x = '0;
    word_ch.point_y = '0;
    word_ch.point_z = '0;
    word_ch.read_ring = '0;
    word_ch.read_sector = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset configuration. The first point, at the origin,
    // clears the grid; then the four axis bearings, two with extreme heights,
    // one point per quadrant, a dropped point, bin reads including the corner
    // of the store, a dropped point with the first flag (it must still clear),
    // and reads after it. Every read carries a random first flag.
    send_word(point_word(0, 0, 0, 1'b1));
    send_word(point_word(5000, 0, 524287, 1'b0));
    send_word(point_word(0, 5000, -524288, 1'b0));
    send_word(point_word(-5000, 0, 100, 1'b0));
    send_word(point_word(0, -5000, -600, 1'b0));
    send_word(point_word(3000, 4000, 7, 1'b0));
    send_word(point_word(-3000, 4000, -512, 1'b0));
    send_word(point_word(-3000, -4000, 1, 1'b0));
    send_word(point_word(3000, -4000, 2, 1'b0));
    send_word(point_word(-524288, 524287, 3, 1'b0));
    send_word(read_word(0, 0));
    send_word(read_word(5, 0));
    send_word(read_word(5, 15));
    send_word(read_word(5, 30));
    send_word(read_word(5, 45));
    send_word(read_word(4, 8));
    send_word(read_word(31, 63));
    send_word(point_word(524287, -524288, 9, 1'b1));
    send_word(read_word(0, 0));
    send_word(read_word(5, 0));

    random_phase(RANDOM_WORDS);
    configure(524287, 360, 32, 64);
    random_phase(RANDOM_WORDS);
    configure(1, 1, 1, 1);
    random_phase(RANDOM_WORDS);
    configure(0, 0, 0, 0);
    random_phase(RANDOM_WORDS / 2);
    configure(300, 90, 63, 127);
    // Long hold-off on the result side while words keep coming.
    hold_request = 1'b1;
    random_phase(RANDOM_WORDS);
    configure(5000, 511, 7, 13);
    random_phase(RANDOM_WORDS);
    configure(20480, 180, 20, 60);
    idle_on = 1'b0;
    random_phase(RANDOM_WORDS);

    wait_quiet();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/scd_pkg.sv
rtl/scd_if.sv
rtl/scd_cordic.sv
rtl/scan_context_descriptor_build.sv
tb/sv/scan_context_descriptor_build_tb.sv
